// ===== src/olist_pkg.sv =====
package olist_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_UP_RD,
    ST_UP_WR,
    ST_PUT,
    ST_DOWN_RD,
    ST_DOWN_WR,
    ST_EXT_RD,
    ST_EXT_CMP,
    ST_FINISH
  } state_e;

  localparam logic [2:0] ModePushFront = 3'd0;
  localparam logic [2:0] ModePushBack  = 3'd1;
  localparam logic [2:0] ModeExtract   = 3'd2;
  localparam logic [2:0] ModeSearch    = 3'd3;
  localparam logic [2:0] ModeRemove    = 3'd4;
  localparam logic [2:0] ModeInsert    = 3'd5;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;
  localparam logic [1:0] StatusMiss  = 2'd3;

  localparam logic signed [4:0] PosNone = -5'sd1;

endpackage

// ===== src/ordered_list_engine.sv =====
// Bounded ordered list of up to DEPTH signed 32-bit values held in a single
// entry memory with one read and one write port. Each request beat is taken
// only while the sequencer is idle; a finished result waits in an output
// register, so the next request may be taken before that result beat leaves.
// Pushing to the back, extracting the tail and unused modes need no shifting
// or scanning and make at most one memory access. Push front and insert shift
// every entry behind the target up by one, and search and remove compare
// entries one by one from the front, with remove then shifting the rest down;
// each such step is a memory read and then its use. A result that is still
// waiting holds the sequencer in its final state. Pushes and inserts on a full
// list report the list as full and change nothing; entry_count and position
// are the low five bits of the count and of the match position.
module ordered_list_engine #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] value_i,
  input  logic [7:0]         index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] extracted_value_o,
  output logic signed [4:0]  position_o,
  output logic [4:0]         entry_count_o,
  output logic               is_empty_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CmpW = (CW > 8) ? CW : 8;

  olist_pkg::state_e state_q, state_d;

  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic [CW-1:0]      tgt_q, tgt_d;
  logic [2:0]         mode_q;
  logic signed [31:0] value_q;
  logic [7:0]         index_q;
  logic [1:0]         status_q, status_d;
  logic signed [31:0] extr_q, extr_d;
  logic signed [4:0]  pos_q, pos_d;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_status_q;
  logic signed [31:0] out_extr_q;
  logic signed [4:0]  out_pos_q;
  logic [4:0]         out_cnt_q;
  logic               out_empty_q;

  logic [31:0]   mem_q [DEPTH];
  logic [31:0]   rd_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [31:0]   mem_wdata;

  logic [CW-1:0] ptr_inc, ptr_dec, ins_tgt;
  logic          accept, full, finish_load, hit;

  assign accept      = in_valid_i && in_ready_o;
  assign full        = (cnt_q == CW'(DEPTH));
  assign ptr_inc     = ptr_q + CW'(1);
  assign ptr_dec     = ptr_q - CW'(1);
  assign hit         = (rd_q == value_q);
  assign finish_load = (state_q == olist_pkg::ST_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    ins_tgt = cnt_q;
    unique case (mode_q) inside
      olist_pkg::ModePushFront: ins_tgt = '0;
      olist_pkg::ModeInsert: begin
        if (CmpW'(index_q) < CmpW'(cnt_q)) begin
          ins_tgt = CW'(index_q);
        end
      end
      default: ins_tgt = cnt_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      olist_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = olist_pkg::ST_DECODE;
        end
      end
      olist_pkg::ST_DECODE: begin
        unique case (mode_q) inside
          olist_pkg::ModePushFront, olist_pkg::ModePushBack, olist_pkg::ModeInsert: begin
            if (full) begin
              state_d = olist_pkg::ST_FINISH;
            end else if (cnt_q == ins_tgt) begin
              state_d = olist_pkg::ST_PUT;
            end else begin
              state_d = olist_pkg::ST_UP_RD;
            end
          end
          olist_pkg::ModeExtract: begin
            state_d = (cnt_q == '0) ? olist_pkg::ST_FINISH : olist_pkg::ST_EXT_RD;
          end
          olist_pkg::ModeSearch, olist_pkg::ModeRemove: begin
            state_d = (cnt_q == '0) ? olist_pkg::ST_FINISH : olist_pkg::ST_SCAN_RD;
          end
          default: state_d = olist_pkg::ST_FINISH;
        endcase
      end
      olist_pkg::ST_SCAN_RD:  state_d = olist_pkg::ST_SCAN_CMP;
      olist_pkg::ST_SCAN_CMP: begin
        if (hit) begin
          if (mode_q == olist_pkg::ModeRemove && ptr_inc < cnt_q) begin
            state_d = olist_pkg::ST_DOWN_RD;
          end else begin
            state_d = olist_pkg::ST_FINISH;
          end
        end else if (ptr_inc == cnt_q) begin
          state_d = olist_pkg::ST_FINISH;
        end else begin
          state_d = olist_pkg::ST_SCAN_RD;
        end
      end
      olist_pkg::ST_UP_RD: state_d = olist_pkg::ST_UP_WR;
      olist_pkg::ST_UP_WR: begin
        state_d = (ptr_dec == tgt_q) ? olist_pkg::ST_PUT : olist_pkg::ST_UP_RD;
      end
      olist_pkg::ST_PUT:     state_d = olist_pkg::ST_FINISH;
      olist_pkg::ST_DOWN_RD: state_d = olist_pkg::ST_DOWN_WR;
      olist_pkg::ST_DOWN_WR: begin
        state_d = (ptr_inc < cnt_q) ? olist_pkg::ST_DOWN_RD : olist_pkg::ST_FINISH;
      end
      olist_pkg::ST_EXT_RD:  state_d = olist_pkg::ST_EXT_CMP;
      olist_pkg::ST_EXT_CMP: state_d = olist_pkg::ST_FINISH;
      olist_pkg::ST_FINISH: begin
        if (finish_load) begin
          state_d = olist_pkg::ST_IDLE;
        end
      end
      default: state_d = olist_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    tgt_d       = tgt_q;
    status_d    = status_q;
    extr_d      = extr_q;
    pos_d       = pos_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = ptr_q[AW-1:0];
    mem_waddr   = ptr_q[AW-1:0];
    mem_wdata   = rd_q;
    in_ready_o  = (state_q == olist_pkg::ST_IDLE);
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      olist_pkg::ST_IDLE: begin
      end
      olist_pkg::ST_DECODE: begin
        status_d = olist_pkg::StatusOk;
        extr_d   = '0;
        pos_d    = '0;
        unique case (mode_q) inside
          olist_pkg::ModePushFront, olist_pkg::ModePushBack, olist_pkg::ModeInsert: begin
            if (full) begin
              status_d = olist_pkg::StatusFull;
            end
            tgt_d = ins_tgt;
            ptr_d = cnt_q;
          end
          olist_pkg::ModeExtract: begin
            if (cnt_q == '0) begin
              status_d = olist_pkg::StatusEmpty;
            end
            ptr_d = cnt_q - CW'(1);
          end
          olist_pkg::ModeSearch, olist_pkg::ModeRemove: begin
            if (cnt_q == '0) begin
              status_d = olist_pkg::StatusMiss;
              if (mode_q == olist_pkg::ModeSearch) begin
                pos_d = olist_pkg::PosNone;
              end
            end
            ptr_d = '0;
          end
          default: begin
          end
        endcase
      end
      olist_pkg::ST_SCAN_RD: mem_re = 1'b1;
      olist_pkg::ST_SCAN_CMP: begin
        if (hit) begin
          if (mode_q == olist_pkg::ModeSearch) begin
            pos_d = 5'(ptr_q);
          end else begin
            cnt_d = cnt_q - CW'(1);
          end
        end else if (ptr_inc == cnt_q) begin
          status_d = olist_pkg::StatusMiss;
          if (mode_q == olist_pkg::ModeSearch) begin
            pos_d = olist_pkg::PosNone;
          end
        end else begin
          ptr_d = ptr_inc;
        end
      end
      olist_pkg::ST_UP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_dec[AW-1:0];
      end
      olist_pkg::ST_UP_WR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_dec;
      end
      olist_pkg::ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = tgt_q[AW-1:0];
        mem_wdata = value_q;
        cnt_d     = cnt_q + CW'(1);
      end
      olist_pkg::ST_DOWN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_inc[AW-1:0];
      end
      olist_pkg::ST_DOWN_WR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_inc;
      end
      olist_pkg::ST_EXT_RD: mem_re = 1'b1;
      olist_pkg::ST_EXT_CMP: begin
        extr_d = rd_q;
        cnt_d  = ptr_q;
      end
      olist_pkg::ST_FINISH: begin
        if (finish_load) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olist_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    tgt_q    <= tgt_d;
    status_q <= status_d;
    extr_q   <= extr_d;
    pos_q    <= pos_d;
    if (accept) begin
      mode_q  <= mode_i;
      value_q <= value_i;
      index_q <= index_i;
    end
    if (finish_load) begin
      out_status_q <= status_q;
      out_extr_q   <= extr_q;
      out_pos_q    <= pos_q;
      out_cnt_q    <= 5'(cnt_q);
      out_empty_q  <= (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign extracted_value_o = out_extr_q;
  assign position_o        = out_pos_q;
  assign entry_count_o     = out_cnt_q;
  assign is_empty_o        = out_empty_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1)) ||
    (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("entry count moved by more than one");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == olist_pkg::StatusFull |-> entry_count_o == 5'(DEPTH))
    else $error("full status reported below depth");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == olist_pkg::StatusEmpty |-> is_empty_o)
    else $error("extract from empty reported a non-empty list");
`endif

endmodule

// ===== sim/ordered_list_engine_test.sv =====
module ordered_list_engine_test;

  localparam int ListDepth = 16;
  localparam logic [2:0] ModeUnused6 = 3'd6;
  localparam logic [2:0] ModeUnused7 = 3'd7;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] extracted;
    logic signed [4:0]  position;
    logic [4:0]         count;
    logic               empty;
  } list_result_t;

  typedef struct {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [7:0]         index;
    int                 reps;
    bit                 typed;
    list_result_t       exp;
  } req_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         mode_i = '0;
  logic signed [31:0] value_i = '0;
  logic [7:0]         index_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] extracted_value_o;
  logic signed [4:0]  position_o;
  logic [4:0]         entry_count_o;
  logic               is_empty_o;

  logic signed [31:0] shadow_list [ListDepth];
  int                 shadow_count = 0;
  list_result_t       pending_results [$];
  list_result_t       head;
  req_row_t           plan [$];
  int                 errors = 0;
  int                 requests_sent = 0;
  int                 results_checked = 0;
  int                 status_seen [4] = '{0, 0, 0, 0};
  int                 rx_hold = 0;
  bit                 tx_calm = 1'b0;
  bit                 rx_calm = 1'b0;

  ordered_list_engine #(
    .DEPTH(ListDepth)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .mode_i(mode_i),
    .value_i(value_i),
    .index_i(index_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o(status_o),
    .extracted_value_o(extracted_value_o),
    .position_o(position_o),
    .entry_count_o(entry_count_o),
    .is_empty_o(is_empty_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic list_result_t apply_to_list(input logic [2:0] mode,
                                                 input logic signed [31:0] value,
                                                 input logic [7:0] index);
    list_result_t res;
    int slot;
    int hit;
    res = '0;
    hit = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (hit < 0 && shadow_list[i] == value) begin
        hit = i;
      end
    end
    case (mode) inside
      olist_pkg::ModePushFront, olist_pkg::ModePushBack, olist_pkg::ModeInsert: begin
        if (shadow_count >= ListDepth) begin
          res.status = olist_pkg::StatusFull;
        end else begin
          if (mode == olist_pkg::ModePushFront) begin
            slot = 0;
          end else if (mode == olist_pkg::ModePushBack || int'(index) >= shadow_count) begin
            slot = shadow_count;
          end else begin
            slot = int'(index);
          end
          for (int i = shadow_count; i > slot; i--) begin
            shadow_list[i] = shadow_list[i - 1];
          end
          shadow_list[slot] = value;
          shadow_count++;
        end
      end
      olist_pkg::ModeExtract: begin
        if (shadow_count == 0) begin
          res.status = olist_pkg::StatusEmpty;
        end else begin
          shadow_count--;
          res.extracted = shadow_list[shadow_count];
        end
      end
      olist_pkg::ModeSearch: begin
        if (hit < 0) begin
          res.status = olist_pkg::StatusMiss;
          res.position = olist_pkg::PosNone;
        end else begin
          res.position = hit[4:0];
        end
      end
      olist_pkg::ModeRemove: begin
        if (hit < 0) begin
          res.status = olist_pkg::StatusMiss;
        end else begin
          for (int i = hit; i + 1 < shadow_count; i++) begin
            shadow_list[i] = shadow_list[i + 1];
          end
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    res.count = shadow_count[4:0];
    res.empty = (shadow_count == 0);
    return res;
  endfunction

  task automatic send_request(input logic [2:0] mode, input logic signed [31:0] value,
                              input logic [7:0] index, input bit typed,
                              input list_result_t typed_exp);
    list_result_t pred;
    in_valid_i <= 1'b1;
    mode_i <= mode;
    value_i <= value;
    index_i <= index;
    do @(posedge clk_i); while (!in_ready_o);
    pred = apply_to_list(mode, value, index);
    pending_results.push_back(typed ? typed_exp : pred);
    requests_sent++;
  endtask

  task automatic tx_pause();
    int gap;
    if (!tx_calm && $urandom_range(0, 99) < 30) begin
      gap = pick_gap();
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [31:0] expv,
                              input logic [31:0] actv);
    if (expv !== actv) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expv, actv);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, status %0d count %0d",
                 $time, status_o, entry_count_o);
      end else begin
        head = pending_results.pop_front();
        report_field("status", 32'(head.status), 32'(status_o));
        report_field("extracted_value", head.extracted, extracted_value_o);
        report_field("position", 32'(head.position), 32'(position_o));
        report_field("entry_count", 32'(head.count), 32'(entry_count_o));
        report_field("is_empty", 32'(head.empty), 32'(is_empty_o));
        status_seen[head.status]++;
        results_checked++;
      end
    end
    if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold--;
    end else begin
      out_ready_i <= 1'b1;
      if (!rx_calm && $urandom_range(0, 99) < 25) begin
        rx_hold = pick_gap();
      end
    end
  end

  initial begin
    logic [2:0]         md;
    logic signed [31:0] val;
    logic [7:0]         idx;
    int                 r;
    bit                 fill;

    plan = '{
      '{olist_pkg::ModeExtract, 32'sd0, 8'd0, 1, 1'b1,
        '{olist_pkg::StatusEmpty, 32'sd0, 5'sd0, 5'd0, 1'b1}},
      '{olist_pkg::ModeSearch, 32'sd0, 8'd0, 1, 1'b1,
        '{olist_pkg::StatusMiss, 32'sd0, olist_pkg::PosNone, 5'd0, 1'b1}},
      '{olist_pkg::ModeRemove, 32'sh7fffffff, 8'd0, 1, 1'b1,
        '{olist_pkg::StatusMiss, 32'sd0, 5'sd0, 5'd0, 1'b1}},
      '{ModeUnused6, 32'sd0, 8'd0, 1, 1'b1,
        '{olist_pkg::StatusOk, 32'sd0, 5'sd0, 5'd0, 1'b1}},
      '{ModeUnused7, -32'sd1, 8'd255, 1, 1'b1,
        '{olist_pkg::StatusOk, 32'sd0, 5'sd0, 5'd0, 1'b1}},
      '{olist_pkg::ModeInsert, 32'sh7fffffff, 8'd7, 1, 1'b1,
        '{olist_pkg::StatusOk, 32'sd0, 5'sd0, 5'd1, 1'b0}},
      '{olist_pkg::ModePushFront, 32'sh80000000, 8'd0, 1, 1'b1,
        '{olist_pkg::StatusOk, 32'sd0, 5'sd0, 5'd2, 1'b0}},
      '{olist_pkg::ModePushBack, 32'sd0, 8'd0, 1, 1'b1,
        '{olist_pkg::StatusOk, 32'sd0, 5'sd0, 5'd3, 1'b0}},
      '{olist_pkg::ModeInsert, -32'sd1, 8'd255, 1, 1'b0, '0},
      '{olist_pkg::ModeInsert, 32'sh55555555, 8'd2, 1, 1'b0, '0},
      '{olist_pkg::ModeInsert, 32'shaaaaaaaa, 8'd1, 1, 1'b0, '0},
      '{olist_pkg::ModeSearch, 32'sd0, 8'd0, 1, 1'b0, '0},
      '{olist_pkg::ModeSearch, 32'sh12345678, 8'd0, 1, 1'b0, '0},
      '{olist_pkg::ModeRemove, 32'sh80000000, 8'd0, 1, 1'b0, '0},
      '{olist_pkg::ModePushFront, 32'sd0, 8'd0, 1, 1'b0, '0},
      '{olist_pkg::ModeRemove, 32'sd0, 8'd0, 1, 1'b0, '0},
      '{olist_pkg::ModeExtract, 32'sd0, 8'd0, 1, 1'b0, '0},
      '{olist_pkg::ModePushBack, 32'sh1234, 8'd0, 12, 1'b0, '0},
      '{olist_pkg::ModePushFront, 32'sd1, 8'd0, 1, 1'b1,
        '{olist_pkg::StatusFull, 32'sd0, 5'sd0, 5'd16, 1'b0}},
      '{olist_pkg::ModePushBack, 32'sd2, 8'd0, 1, 1'b1,
        '{olist_pkg::StatusFull, 32'sd0, 5'sd0, 5'd16, 1'b0}},
      '{olist_pkg::ModeInsert, 32'sd3, 8'd3, 1, 1'b1,
        '{olist_pkg::StatusFull, 32'sd0, 5'sd0, 5'd16, 1'b0}},
      '{olist_pkg::ModeSearch, 32'sh1234, 8'd0, 1, 1'b0, '0},
      '{olist_pkg::ModeRemove, 32'sh1234, 8'd0, 1, 1'b0, '0},
      '{olist_pkg::ModeExtract, 32'sd0, 8'd0, 1, 1'b0, '0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < plan.size(); k++) begin
      for (int n = 0; n < plan[k].reps; n++) begin
        send_request(plan[k].mode, plan[k].value, plan[k].index, plan[k].typed,
                     plan[k].exp);
        tx_pause();
      end
    end
    wait_for_results();

    // Even phases lean toward growing the list until it is full, odd phases
    // toward draining it, so both ends of the occupancy range are visited.
    for (int ph = 0; ph < 10; ph++) begin
      fill = (ph % 2 == 0);
      tx_calm = (ph % 4 == 1);
      rx_calm = (ph % 3 == 2);
      for (int n = 0; n < 190; n++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          md = (r == 0) ? ModeUnused6 : ModeUnused7;
        end else if (r < (fill ? 77 : 32)) begin
          case ($urandom_range(0, 2))
            0: md = olist_pkg::ModePushFront;
            1: md = olist_pkg::ModePushBack;
            default: md = olist_pkg::ModeInsert;
          endcase
        end else if (r < (fill ? 82 : 62)) begin
          md = olist_pkg::ModeExtract;
        end else if (r < (fill ? 92 : 80)) begin
          md = olist_pkg::ModeSearch;
        end else begin
          md = olist_pkg::ModeRemove;
        end
        r = $urandom_range(0, 99);
        if (r < 20) begin
          case ($urandom_range(0, 4))
            0: val = 32'sh7fffffff;
            1: val = 32'sh80000000;
            2: val = -32'sd1;
            3: val = 32'sd0;
            default: val = 32'(signed'($urandom_range(1, 6)));
          endcase
        end else if (r < 70 && shadow_count > 0) begin
          val = shadow_list[$urandom_range(0, shadow_count - 1)];
        end else begin
          val = $urandom;
        end
        idx = ($urandom_range(0, 99) < 30) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 17));
        send_request(md, val, idx, 1'b0, '0);
        tx_pause();
      end
      if (ph % 2 == 1) begin
        wait_for_results();
      end
    end

    wait_for_results();
    repeat (48) @(posedge clk_i);
    $display("Sent %0d requests across directed and fill/drain phases, checked %0d beats.",
             requests_sent, results_checked);
    $display("Statuses seen: ok %0d, extract-empty %0d, full %0d, not-found %0d.",
             status_seen[olist_pkg::StatusOk], status_seen[olist_pkg::StatusEmpty],
             status_seen[olist_pkg::StatusFull], status_seen[olist_pkg::StatusMiss]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
